/* src/ndfs_pkg.sv */
`default_nettype none
package ndfs_pkg;

  typedef struct packed {
    logic [1:0] unit_select;
    logic [6:0] value;
  } in_req_t;

  typedef struct packed {
    logic       line_level;
    logic [3:0] slot_periods;
    logic       last_slot;
  } out_res_t;

  // Classified work handed from the front end to the serializer
  typedef struct packed {
    logic [2:0] addr;
    logic [3:0] ones;
    logic [3:0] tens;
  } frame_cmd_t;

  localparam logic [1:0] UNIT_SECONDS = 2'd0;
  localparam logic [1:0] UNIT_MINUTES = 2'd1;
  localparam logic [1:0] UNIT_HOURS   = 2'd2;

  localparam logic [2:0] ADDR_SECONDS = 3'b001;
  localparam logic [2:0] ADDR_MINUTES = 3'b011;
  localparam logic [2:0] ADDR_HOURS   = 3'b101;

  localparam logic [6:0] MAX_VALUE     = 7'd99;
  localparam int         FRAME_SLOTS   = 10;
  localparam int         ITEM_SLOTS    = 2 * FRAME_SLOTS + 1;
  localparam int         SLOT_W        = $clog2(ITEM_SLOTS);
  localparam logic [3:0] UNIT_PERIODS  = 4'd1;

  // Frame slot positions
  localparam logic [3:0] POS_START = 4'd0;
  localparam logic [3:0] POS_SYNC  = 4'd1;
  localparam logic [3:0] POS_A2    = 4'd2;
  localparam logic [3:0] POS_A1    = 4'd3;
  localparam logic [3:0] POS_A0    = 4'd4;
  localparam logic [3:0] POS_D0    = 4'd5;
  localparam logic [3:0] POS_D1    = 4'd6;
  localparam logic [3:0] POS_D2    = 4'd7;
  localparam logic [3:0] POS_D3    = 4'd8;
  localparam logic [3:0] POS_STOP  = 4'd9;

  function automatic logic [2:0] unit_addr(input logic [1:0] unit);
    logic [2:0] a;
    unique case (unit)
      UNIT_SECONDS: a = ADDR_SECONDS;
      UNIT_MINUTES: a = ADDR_MINUTES;
      UNIT_HOURS:   a = ADDR_HOURS;
      default:      a = ADDR_HOURS;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

/* src/nixie_digit_frame_serializer_unit.sv */
`default_nettype none
// Nixie digit frame serializer. Each request (unit, value) becomes 21 line
// slots: the ones frame, the tens frame (each low, high, 3-bit unit address
// MSB first, 4 digit bits LSB first, high) and a closing high slot of
// END_HOLD_PERIODS bit periods flagged by last_slot. Values above 99 read as
// 99; unit code 3 uses the hours address. The serializer's slot counter
// emits one slot per cycle while the output is not stalled; with the
// output never stalled and the next request already queued, slots stream
// with no gaps between requests. A two-entry queue between the input
// classifier and the serializer lets new requests be taken while a frame
// is still going out. With the serializer idle, an accepted request is
// written into the queue and its first slot is then registered out.
module nixie_digit_frame_serializer_unit import ndfs_pkg::*; #(
  parameter int END_HOLD_PERIODS = 10
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_req_t  in_req,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_res_t      out_res
);

  logic       push, pop, queue_full, q_valid;
  frame_cmd_t push_cmd, q_cmd;

  ndfs_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  ndfs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  ndfs_back #(
    .END_HOLD_PERIODS (END_HOLD_PERIODS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  a_end_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.last_slot) |->
      (out_res.slot_periods == 4'(END_HOLD_PERIODS) && out_res.line_level))
    else $error("end slot has wrong length or level");

  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.last_slot) |-> (out_res.slot_periods == UNIT_PERIODS))
    else $error("frame slot is not one bit period");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_res.last_slot) |=> out_valid)
    else $error("gap inside a request's slot stream");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("serializer took from an empty queue");

endmodule
`default_nettype wire

/* src/ndfs_front.sv */
`default_nettype none
module ndfs_front import ndfs_pkg::*; (
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_req_t    in_req,
  output logic            push,
  output frame_cmd_t      push_cmd,
  input  wire logic       queue_full
);

  logic [6:0]  sat_val;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;

  always_comb begin
    sat_val  = (in_req.value > MAX_VALUE) ? MAX_VALUE : in_req.value;
    // value / 10 as multiply by 205 >> 11, exact for 0..99
    prod     = 15'({8'd0, sat_val} * 15'd205);
    tens     = prod[14:11];
    tens_x10 = 7'({3'd0, tens} * 7'd10);
    push_cmd.addr = unit_addr(in_req.unit_select);
    push_cmd.tens = tens;
    push_cmd.ones = 4'(sat_val - tens_x10);
  end

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

endmodule
`default_nettype wire

/* src/ndfs_queue.sv */
`default_nettype none
module ndfs_queue import ndfs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire frame_cmd_t  push_cmd,
  output logic             full,
  input  wire logic        pop,
  output logic             q_valid,
  output frame_cmd_t       q_cmd
);

  frame_cmd_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

/* src/ndfs_back.sv */
`default_nettype none
module ndfs_back import ndfs_pkg::*; #(
  parameter int END_HOLD_PERIODS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire frame_cmd_t  q_cmd,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_res_t         out_res
);

  localparam logic [SLOT_W-1:0] LAST_IDX  = SLOT_W'(ITEM_SLOTS - 1);
  localparam logic [SLOT_W-1:0] FRAME_LEN = SLOT_W'(FRAME_SLOTS);

  frame_cmd_t        cmd_r, cmd_nxt;
  logic              busy_r, busy_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_res_r, out_res_nxt;

  frame_cmd_t        cur;
  logic              active, adv;
  logic [SLOT_W-1:0] rel;
  logic [3:0]        pos;
  logic [3:0]        digit;
  logic              level;

  always_comb begin
    cur    = busy_r ? cmd_r : q_cmd;
    active = busy_r || q_valid;
    adv    = !out_valid_r || !out_stall;
    pop    = adv && !busy_r && q_valid;

    // Ones frame first, then tens frame
    rel   = (slot_r >= FRAME_LEN) ? slot_r - FRAME_LEN : slot_r;
    pos   = rel[3:0];
    digit = (slot_r >= FRAME_LEN) ? cur.tens : cur.ones;

    unique case (pos)
      POS_START: level = 1'b0;
      POS_SYNC:  level = 1'b1;
      POS_A2:    level = cur.addr[2];
      POS_A1:    level = cur.addr[1];
      POS_A0:    level = cur.addr[0];
      POS_D0:    level = digit[0];
      POS_D1:    level = digit[1];
      POS_D2:    level = digit[2];
      POS_D3:    level = digit[3];
      POS_STOP:  level = 1'b1;
      default:   level = 1'b1;
    endcase

    out_res_nxt.line_level   = (slot_r == LAST_IDX) ? 1'b1 : level;
    out_res_nxt.slot_periods = (slot_r == LAST_IDX) ? 4'(END_HOLD_PERIODS) : UNIT_PERIODS;
    out_res_nxt.last_slot    = (slot_r == LAST_IDX);
  end

  always_comb begin
    cmd_nxt       = pop ? q_cmd : cmd_r;
    busy_nxt      = busy_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = active;
      if (active) begin
        busy_nxt = (slot_r != LAST_IDX);
        slot_nxt = (slot_r == LAST_IDX) ? '0 : slot_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (adv && active) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
`default_nettype wire

/* dv/ndfs_line_checker.sv */
module ndfs_line_checker import ndfs_pkg::*; #(
  parameter int END_HOLD_PERIODS = 10
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  in_req_t  in_req,
  input  logic     out_valid,
  input  logic     out_stall,
  input  out_res_t out_res,
  output int       slot_errors,
  output int       slots_pending
);

  out_res_t expected_slots[$];
  out_res_t want_slot;
  int       err_count = 0;

  function automatic void push_slot(input logic level, input logic [3:0] periods,
                                    input logic last);
    out_res_t s;
    s.line_level   = level;
    s.slot_periods = periods;
    s.last_slot    = last;
    expected_slots.push_back(s);
  endfunction

  // Address goes out MSB first, digit LSB first.
  function automatic void push_frame(input logic [2:0] addr, input logic [3:0] digit);
    push_slot(1'b0, UNIT_PERIODS, 1'b0);
    push_slot(1'b1, UNIT_PERIODS, 1'b0);
    for (int b = 2; b >= 0; b--) begin
      push_slot(addr[b], UNIT_PERIODS, 1'b0);
    end
    for (int b = 0; b < 4; b++) begin
      push_slot(digit[b], UNIT_PERIODS, 1'b0);
    end
    push_slot(1'b1, UNIT_PERIODS, 1'b0);
  endfunction

  function automatic void queue_item_slots(input in_req_t req);
    logic [2:0] addr;
    logic [6:0] val;
    logic [6:0] ones;
    logic [6:0] tens;
    case (req.unit_select)
      UNIT_SECONDS: addr = ADDR_SECONDS;
      UNIT_MINUTES: addr = ADDR_MINUTES;
      // the spare unit code lands on the hours tubes
      default:      addr = ADDR_HOURS;
    endcase
    val  = (req.value > MAX_VALUE) ? MAX_VALUE : req.value;
    ones = val % 7'd10;
    tens = val / 7'd10;
    push_frame(addr, ones[3:0]);
    push_frame(addr, tens[3:0]);
    push_slot(1'b1, 4'(END_HOLD_PERIODS), 1'b1);
  endfunction

  function automatic void note_mismatch(input bit have_want, input out_res_t want,
                                        input out_res_t got);
    err_count++;
    if (err_count <= 10) begin
      if (have_want) begin
        $display({"line slot mismatch: expected level=%0d periods=%0d last=%0d,",
                  " got level=%0d periods=%0d last=%0d"},
                 want.line_level, want.slot_periods, want.last_slot,
                 got.line_level, got.slot_periods, got.last_slot);
      end else begin
        $display({"line slot with no request pending:",
                  " got level=%0d periods=%0d last=%0d"},
                 got.line_level, got.slot_periods, got.last_slot);
      end
    end
  endfunction

  // Check outputs before queueing the request taken at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_slots.size() == 0) begin
          note_mismatch(1'b0, '0, out_res);
        end else begin
          want_slot = expected_slots.pop_front();
          if (out_res.line_level !== want_slot.line_level ||
              out_res.slot_periods !== want_slot.slot_periods ||
              out_res.last_slot !== want_slot.last_slot) begin
            note_mismatch(1'b1, want_slot, out_res);
          end
        end
      end
      if (in_valid && !in_stall) begin
        queue_item_slots(in_req);
      end
    end
    slots_pending <= expected_slots.size();
    slot_errors   <= err_count;
  end

endmodule

/* dv/tb_nixie_digit_frame_serializer_unit.sv */
module tb_nixie_digit_frame_serializer_unit;
  import ndfs_pkg::*;

  localparam int         HOLD_PERIODS = 10;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         END_SLACK    = 40;
  localparam int         PHASE_ITEMS  = 110;
  localparam logic [1:0] UNIT_SPARE   = 2'd3;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_res;

  int slot_errors;
  int slots_pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;

  int phase_send_idle[4]  = '{0, 84, 0, 30};
  int phase_recv_stall[4] = '{0, 0, 84, 30};

  nixie_digit_frame_serializer_unit #(
    .END_HOLD_PERIODS(HOLD_PERIODS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  ndfs_line_checker #(
    .END_HOLD_PERIODS(HOLD_PERIODS)
  ) line_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req        (in_req),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res       (out_res),
    .slot_errors   (slot_errors),
    .slots_pending (slots_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_nixie_digit_frame_serializer_unit: FAIL");
      $finish;
    end
  end

  // Hold valid and payload until the request is taken.
  task automatic send_req(input logic [1:0] unit, input logic [6:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_req.unit_select <= unit;
    in_req.value       <= value;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_lines_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (slots_pending != 0) @(posedge clk);
  endtask

  task automatic send_random_req();
    logic [6:0] value;
    if ($urandom_range(9) == 0) begin
      value = 7'($urandom_range(127, 100));
    end else begin
      value = 7'($urandom_range(99));
    end
    send_req(2'($urandom_range(3)), value);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(UNIT_SECONDS, 7'd0);
    send_req(UNIT_SECONDS, 7'd99);
    send_req(UNIT_MINUTES, 7'd59);
    send_req(UNIT_HOURS,   7'd23);
    send_req(UNIT_HOURS,   7'd9);
    send_req(UNIT_MINUTES, 7'd10);
    send_req(UNIT_SPARE,   7'd45);
    send_req(UNIT_SECONDS, 7'd100);
    send_req(UNIT_MINUTES, 7'd127);
    send_req(UNIT_SPARE,   7'd127);
    send_req(UNIT_HOURS,   7'd90);
    send_req(UNIT_SECONDS, 7'd1);
    send_req(UNIT_MINUTES, 7'd64);
    send_req(UNIT_HOURS,   7'd88);
    wait_lines_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_send_idle[p];
      recv_stall_pct = phase_recv_stall[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_random_req();
        if ($urandom_range(39) == 0) begin
          wait_lines_drained();
        end
      end
      wait_lines_drained();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_lines_drained();
    repeat (END_SLACK) @(posedge clk);
    if (slot_errors == 0 && slots_pending == 0) begin
      $display("tb_nixie_digit_frame_serializer_unit: PASS");
    end else begin
      $display("tb_nixie_digit_frame_serializer_unit: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
src/ndfs_pkg.sv
src/ndfs_front.sv
src/ndfs_queue.sv
src/ndfs_back.sv
src/nixie_digit_frame_serializer_unit.sv
dv/ndfs_line_checker.sv
dv/tb_nixie_digit_frame_serializer_unit.sv
